// File: hw/rtl/rfa_pkg.sv
`default_nettype none
package rfa_pkg;

  // Width of the operand fields on the input channel.
  localparam int IN_W = 32;
  // Width of every internal value and of the result fields.
  localparam int DATA_W = 64;
  // Step counter of the serial divider, wide enough to hold DATA_W.
  localparam int CNT_W = $clog2(DATA_W + 1);
  // Default number of operand bits that are used, sign-extended.
  localparam int OPERAND_BITS_DEF = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // Handshake between the sequencer and a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/rfa_if.sv
`default_nettype none
interface rfa_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        op;
  logic signed [rfa_pkg::IN_W-1:0]   a_num;
  logic signed [rfa_pkg::IN_W-1:0]   a_den;
  logic signed [rfa_pkg::IN_W-1:0]   b_num;
  logic signed [rfa_pkg::IN_W-1:0]   b_den;

  modport source(output valid, op, a_num, a_den, b_num, b_den, input ready);
  modport sink(input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rfa_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rfa_pkg::DATA_W-1:0] res_num;
  logic signed [rfa_pkg::DATA_W-1:0] res_den;
  logic                              bad_operand;

  modport source(output valid, res_num, res_den, bad_operand, input ready);
  modport sink(input valid, res_num, res_den, bad_operand, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rational_fraction_alu_core.sv
`default_nettype none
// Rational arithmetic unit. Each input beat carries an operation (add, subtract,
// multiply, divide) and two fractions with signed numerators and denominators; each
// item yields exactly one result beat holding the fraction reduced by its Euclidean
// GCD, with signs as C's truncating division gives them. A zero denominator in add
// or subtract, or a zero GCD, raises bad_operand with a zero numerator and
// denominator. Only the low OPERAND_BITS bits of each operand are used, sign-extended.
// Items are processed one at a time by a sequencer around one bit-serial divider
// and one bit-serial multiplier, both 64 bits wide. Multiply and divide need two
// products, one GCD and two reducing divisions; add and subtract add a first GCD,
// three divisions and three products. Each Euclid step is one division, so the
// latency grows with the number of Euclid steps. The result sits in an output
// register, so the next item is accepted while the previous result beat still
// waits to be taken.
module rational_fraction_alu_core #(
  parameter int OPERAND_BITS = rfa_pkg::OPERAND_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rfa_in_if.sink    in_chan,
  rfa_out_if.source out_chan
);
  import rfa_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE = 15'b000000000000001,
    ST_PREP = 15'b000000000000010,
    ST_GCD  = 15'b000000000000100,
    ST_DQ   = 15'b000000000001000,
    ST_MCOM = 15'b000000000010000,
    ST_DA   = 15'b000000000100000,
    ST_MA   = 15'b000000001000000,
    ST_DB   = 15'b000000010000000,
    ST_MB   = 15'b000000100000000,
    ST_MN   = 15'b000001000000000,
    ST_MD   = 15'b000010000000000,
    ST_RN   = 15'b000100000000000,
    ST_RD   = 15'b001000000000000,
    ST_OUT  = 15'b010000000000000,
    ST_SPARE = 15'b100000000000000
  } state_t;

  // Sign-extends the used low bits of an operand field to the internal width.
  function automatic logic [DATA_W-1:0] sext(input logic [IN_W-1:0] v);
    sext = {{(DATA_W-OPERAND_BITS){v[OPERAND_BITS-1]}}, v[OPERAND_BITS-1:0]};
  endfunction

  state_t            state_r;
  logic              launched_r;  // the unit for the current step has been started
  logic              pass_r;      // 0: GCD of the denominators, 1: final reduction
  logic [1:0]        op_r;
  logic [DATA_W-1:0] an_r, ad_r, bn_r, bd_r;
  logic [DATA_W-1:0] ga_r, gb_r, tmp_r, common_r, ta_r, num_r, den_r;
  logic              bad_r;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_num_r, out_den_r;
  logic              out_bad_r;

  logic              div_step, mul_step, div_start, mul_start;
  logic [DATA_W-1:0] div_a, div_b, mul_a, mul_b;
  logic [DATA_W-1:0] div_quot, div_rem, mul_prod, sum_mix;
  unit_stat_t        div_stat, mul_stat;
  logic              in_acc, out_free;

  // Steps that use a unit; the GCD step only divides while its divisor is non-zero.
  always_comb begin
    div_step = 1'b0;
    mul_step = 1'b0;
    div_a    = '0;
    div_b    = '0;
    mul_a    = '0;
    mul_b    = '0;
    case (state_r)
      ST_GCD: begin
        div_step = (gb_r != '0);
        div_a    = ga_r;
        div_b    = gb_r;
      end
      ST_DQ: begin
        div_step = 1'b1;
        div_a    = ad_r;
        div_b    = ga_r;
      end
      ST_DA: begin
        div_step = 1'b1;
        div_a    = common_r;
        div_b    = ad_r;
      end
      ST_DB: begin
        div_step = 1'b1;
        div_a    = common_r;
        div_b    = bd_r;
      end
      ST_RN: begin
        div_step = 1'b1;
        div_a    = num_r;
        div_b    = ga_r;
      end
      ST_RD: begin
        div_step = 1'b1;
        div_a    = den_r;
        div_b    = ga_r;
      end
      ST_MCOM: begin
        mul_step = 1'b1;
        mul_a    = tmp_r;
        mul_b    = bd_r;
      end
      ST_MA: begin
        mul_step = 1'b1;
        mul_a    = tmp_r;
        mul_b    = an_r;
      end
      ST_MB: begin
        mul_step = 1'b1;
        mul_a    = tmp_r;
        mul_b    = bn_r;
      end
      ST_MN: begin
        mul_step = 1'b1;
        mul_a    = an_r;
        mul_b    = (op_r == OP_MUL) ? bn_r : bd_r;
      end
      ST_MD: begin
        mul_step = 1'b1;
        mul_a    = ad_r;
        mul_b    = (op_r == OP_MUL) ? bd_r : bn_r;
      end
      default: begin
        div_step = 1'b0;
      end
    endcase
  end

  assign div_start = div_step && !launched_r;
  assign mul_start = mul_step && !launched_r;
  assign sum_mix   = (op_r == OP_ADD) ? (ta_r + mul_prod) : (ta_r - mul_prod);

  rfa_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .stat     (div_stat),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  rfa_serial_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_a),
    .mplier (mul_b),
    .stat   (mul_stat),
    .prod   (mul_prod)
  );

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // In the output state a taken beat is replaced by the new one below.
      if (out_valid_r && out_chan.ready && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      if (div_start || mul_start) begin
        launched_r <= 1'b1;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            op_r    <= in_chan.op;
            an_r    <= sext(in_chan.a_num);
            ad_r    <= sext(in_chan.a_den);
            bn_r    <= sext(in_chan.b_num);
            bd_r    <= sext(in_chan.b_den);
            bad_r   <= 1'b0;
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (op_r == OP_ADD || op_r == OP_SUB) begin
            if (ad_r == '0 || bd_r == '0) begin
              bad_r   <= 1'b1;
              num_r   <= '0;
              den_r   <= '0;
              state_r <= ST_OUT;
            end else begin
              ga_r    <= ad_r;
              gb_r    <= bd_r;
              pass_r  <= 1'b0;
              state_r <= ST_GCD;
            end
          end else begin
            state_r <= ST_MN;
          end
        end
        ST_GCD: begin
          if (launched_r) begin
            if (div_stat.done) begin
              ga_r       <= gb_r;
              gb_r       <= div_rem;
              launched_r <= 1'b0;
            end
          end else if (gb_r == '0) begin
            if (!pass_r) begin
              state_r <= ST_DQ;
            end else if (ga_r == '0) begin
              // Both values zero: no GCD to divide by.
              bad_r   <= 1'b1;
              num_r   <= '0;
              den_r   <= '0;
              state_r <= ST_OUT;
            end else begin
              state_r <= ST_RN;
            end
          end
        end
        ST_DQ: begin
          if (launched_r && div_stat.done) begin
            tmp_r      <= div_quot;
            launched_r <= 1'b0;
            state_r    <= ST_MCOM;
          end
        end
        ST_MCOM: begin
          if (launched_r && mul_stat.done) begin
            common_r   <= mul_prod;
            launched_r <= 1'b0;
            state_r    <= ST_DA;
          end
        end
        ST_DA: begin
          if (launched_r && div_stat.done) begin
            tmp_r      <= div_quot;
            launched_r <= 1'b0;
            state_r    <= ST_MA;
          end
        end
        ST_MA: begin
          if (launched_r && mul_stat.done) begin
            ta_r       <= mul_prod;
            launched_r <= 1'b0;
            state_r    <= ST_DB;
          end
        end
        ST_DB: begin
          if (launched_r && div_stat.done) begin
            tmp_r      <= div_quot;
            launched_r <= 1'b0;
            state_r    <= ST_MB;
          end
        end
        ST_MB: begin
          if (launched_r && mul_stat.done) begin
            num_r      <= sum_mix;
            den_r      <= common_r;
            ga_r       <= sum_mix;
            gb_r       <= common_r;
            pass_r     <= 1'b1;
            launched_r <= 1'b0;
            state_r    <= ST_GCD;
          end
        end
        ST_MN: begin
          if (launched_r && mul_stat.done) begin
            num_r      <= mul_prod;
            launched_r <= 1'b0;
            state_r    <= ST_MD;
          end
        end
        ST_MD: begin
          if (launched_r && mul_stat.done) begin
            den_r      <= mul_prod;
            ga_r       <= num_r;
            gb_r       <= mul_prod;
            pass_r     <= 1'b1;
            launched_r <= 1'b0;
            state_r    <= ST_GCD;
          end
        end
        ST_RN: begin
          if (launched_r && div_stat.done) begin
            num_r      <= div_quot;
            launched_r <= 1'b0;
            state_r    <= ST_RD;
          end
        end
        ST_RD: begin
          if (launched_r && div_stat.done) begin
            den_r      <= div_quot;
            launched_r <= 1'b0;
            state_r    <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_num_r   <= num_r;
            out_den_r   <= den_r;
            out_bad_r   <= bad_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_chan.ready        = (state_r == ST_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.res_num     = out_num_r;
  assign out_chan.res_den     = out_den_r;
  assign out_chan.bad_operand = out_bad_r;

  // An accepted beat always leaves the idle state.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != ST_IDLE)
    else $error("accepted beat did not start processing");

  // A flagged result carries zeros.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> (out_num_r == '0 && out_den_r == '0))
    else $error("bad_operand result with non-zero fields");

  // Units are only started when idle.
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier restarted while busy");

  // Only one unit works at a time.
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_stat.busy && mul_stat.busy))
    else $error("divider and multiplier busy together");

endmodule
`default_nettype wire

// File: hw/rtl/rfa_serial_div.sv
`default_nettype none
// Signed truncating divider, one quotient bit per cycle on magnitudes.
module rfa_serial_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [rfa_pkg::DATA_W-1:0] dividend,
  input  wire logic [rfa_pkg::DATA_W-1:0] divisor,
  output rfa_pkg::unit_stat_t            stat,
  output logic [rfa_pkg::DATA_W-1:0]     quot,
  output logic [rfa_pkg::DATA_W-1:0]     rem
);
  import rfa_pkg::*;

  logic [DATA_W-1:0] q_r, r_r, dvs_r;
  logic              neg_q_r, neg_r_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [DATA_W:0]   rem_sh, diff;
  logic              fits;

  always_comb begin
    rem_sh = {r_r, q_r[DATA_W-1]};
    diff   = rem_sh - {1'b0, dvs_r};
    fits   = ~diff[DATA_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        cnt_r   <= CNT_W'(DATA_W);
        q_r     <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
        dvs_r   <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
        r_r     <= '0;
        neg_q_r <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        neg_r_r <= dividend[DATA_W-1];
      end else if (busy_r) begin
        q_r   <= {q_r[DATA_W-2:0], fits};
        r_r   <= fits ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quot      = neg_q_r ? (~q_r + 1'b1) : q_r;
  assign rem       = neg_r_r ? (~r_r + 1'b1) : r_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

// File: hw/rtl/rfa_serial_mul.sv
`default_nettype none
// Shift-and-add multiplier, one multiplier bit per cycle, product wraps to DATA_W.
// It stops as soon as no set multiplier bits remain.
module rfa_serial_mul (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [rfa_pkg::DATA_W-1:0] mcand,
  input  wire logic [rfa_pkg::DATA_W-1:0] mplier,
  output rfa_pkg::unit_stat_t            stat,
  output logic [rfa_pkg::DATA_W-1:0]     prod
);
  import rfa_pkg::*;

  logic [DATA_W-1:0] acc_r, mc_r, mp_r;
  logic              busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        acc_r  <= '0;
        mc_r   <= mcand;
        mp_r   <= mplier;
      end else if (busy_r) begin
        if (mp_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          if (mp_r[0]) begin
            acc_r <= acc_r + mc_r;
          end
          mc_r <= {mc_r[DATA_W-2:0], 1'b0};
          mp_r <= {1'b0, mp_r[DATA_W-1:1]};
        end
      end
    end
  end

  assign prod      = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

// File: sim/rational_fraction_alu_core_test.sv
module rational_fraction_alu_core_test;
  import rfa_pkg::*;

  // Everything the predictor needs from one result beat.
  typedef struct {
    logic signed [63:0] num;
    logic signed [63:0] den;
    logic               bad;
  } fraction_t;

  logic clk;
  logic rst_n;

  rfa_in_if  in_chan ();
  rfa_out_if out_chan ();

  rational_fraction_alu_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  // Reduced fractions still owed by the block, oldest first.
  fraction_t pending_fractions[$];
  int        mismatch_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Truncating quotient with two's complement wrap, as C gives it on 64-bit values.
  function automatic logic signed [63:0] trunc_quot(logic signed [63:0] a,
                                                     logic signed [63:0] b);
    if (b == 0) begin
      return 0;
    end
    if (b == -1) begin
      return 64'd0 - a;
    end
    return a / b;
  endfunction

  function automatic logic signed [63:0] trunc_rem(logic signed [63:0] a,
                                                    logic signed [63:0] b);
    if (b == 0 || b == -1) begin
      return 0;
    end
    return a % b;
  endfunction

  function automatic logic signed [63:0] euclid_gcd(logic signed [63:0] a,
                                                     logic signed [63:0] b);
    logic signed [63:0] r;
    while (b != 0) begin
      r = trunc_rem(a, b);
      a = b;
      b = r;
    end
    return a;
  endfunction

  // Computes the reduced fraction for one item; products wrap at 64 bits.
  function automatic fraction_t reduce_fraction(op_t op, logic signed [31:0] an,
                                                logic signed [31:0] ad,
                                                logic signed [31:0] bn,
                                                logic signed [31:0] bd);
    fraction_t          f;
    logic signed [63:0] an64, ad64, bn64, bd64, common, ta, tb, g;
    an64 = an;
    ad64 = ad;
    bn64 = bn;
    bd64 = bd;
    f.bad = 1'b0;
    case (op)
      OP_ADD, OP_SUB: begin
        if (ad64 == 0 || bd64 == 0) begin
          f.bad = 1'b1;
        end else begin
          common = trunc_quot(ad64, euclid_gcd(ad64, bd64)) * bd64;
          ta = trunc_quot(common, ad64) * an64;
          tb = trunc_quot(common, bd64) * bn64;
          f.num = (op == OP_ADD) ? ta + tb : ta - tb;
          f.den = common;
        end
      end
      OP_MUL: begin
        f.num = an64 * bn64;
        f.den = ad64 * bd64;
      end
      default: begin
        f.num = an64 * bd64;
        f.den = ad64 * bn64;
      end
    endcase
    if (!f.bad) begin
      g = euclid_gcd(f.num, f.den);
      if (g == 0) begin
        f.bad = 1'b1;
      end else begin
        f.num = trunc_quot(f.num, g);
        f.den = trunc_quot(f.den, g);
      end
    end
    if (f.bad) begin
      f.num = 0;
      f.den = 0;
    end
    return f;
  endfunction

  // Items left in the sender's burst: bursts of random length separated by random gaps.
  int burst_left;

  // Sends one item as a single beat, predicting its result when it is accepted.
  // Valid stays high between beats of a burst and drops only for a gap.
  task automatic send_item(op_t op, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_chan.valid <= 1'b1;
    in_chan.op    <= op;
    in_chan.a_num <= an;
    in_chan.a_den <= ad;
    in_chan.b_num <= bn;
    in_chan.b_den <= bd;
    do begin
      @(posedge clk);
    end while (!in_chan.ready);
    pending_fractions.push_back(reduce_fraction(op, an, ad, bn, bd));
  endtask

  // Operand values that favour small magnitudes, zeros and the extremes, so that
  // the Euclid loops stay short on most items while every bit still toggles.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'h8000_0000;
      2:       return 32'h7fff_ffff;
      3:       return $urandom;
      4:       return -$urandom_range(1, 1000);
      5:       return $urandom_range(1, 65536) * $urandom_range(1, 64);
      default: return $urandom_range(1, 200) * (($urandom_range(0, 1) != 0) ? 1 : -1);
    endcase
  endfunction

  function automatic logic [31:0] pick_denominator();
    return ($urandom_range(0, 19) == 0) ? 32'd0 : pick_operand();
  endfunction

  task automatic test_extremes();
    op_t op;
    for (int k = 0; k < 4; k++) begin
      op = op_t'(k);
      send_item(op, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
      send_item(op, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_item(op, 32'hffff_ffff, 32'd3, 32'd1, 32'hffff_fffa);
      send_item(op, 32'd0, 32'd0, 32'd0, 32'd0);
    end
  endtask

  task automatic test_special_cases();
    // Zero denominator in add and subtract raises the error.
    send_item(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd2);
    send_item(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd0);
    // Both products zero in multiply and divide: a zero GCD.
    send_item(OP_MUL, 32'd0, 32'd5, 32'd7, 32'd0);
    send_item(OP_DIV, 32'd0, 32'd5, 32'd0, 32'd3);
    // Only the denominator product zero: one over zero.
    send_item(OP_MUL, 32'hffff_fff9, 32'd0, 32'd3, 32'd4);
    send_item(OP_DIV, 32'd6, 32'd5, 32'd0, 32'd3);
    // Ordinary small values with mixed signs.
    send_item(OP_ADD, 32'd1, 32'd6, 32'hffff_fffd, 32'd4);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      send_item(op_t'($urandom_range(0, 3)), pick_operand(), pick_denominator(),
                pick_operand(), pick_denominator());
    end
  endtask

  // The receiver stalls on a pattern of its own: long runs always ready, then
  // stretches of random stalling.
  int ready_phase;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      ready_phase    <= 0;
    end else begin
      ready_phase <= (ready_phase + 1) % 300;
      if (ready_phase < 100) begin
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  // Each result beat is checked against the oldest expectation.
  always @(posedge clk) begin
    fraction_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_fractions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result beat: num %0d den %0d bad %0b",
                   out_chan.res_num, out_chan.res_den, out_chan.bad_operand);
        end
      end else begin
        want = pending_fractions.pop_front();
        if (out_chan.res_num !== want.num || out_chan.res_den !== want.den ||
            out_chan.bad_operand !== want.bad) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected %0d/%0d bad %0b, got %0d/%0d bad %0b",
                     want.num, want.den, want.bad, out_chan.res_num,
                     out_chan.res_den, out_chan.bad_operand);
          end
        end
      end
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.op     = OP_ADD;
    in_chan.a_num  = '0;
    in_chan.a_den  = '0;
    in_chan.b_num  = '0;
    in_chan.b_den  = '0;
    mismatch_count = 0;
    burst_left     = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_special_cases();
    test_random(1500);
    in_chan.valid <= 1'b0;

    // Drain the remaining results, then allow a quiet tail for stray beats.
    while (pending_fractions.size() != 0) begin
      @(posedge clk);
    end
    repeat (5000) @(posedge clk);
    if (mismatch_count == 0 && pending_fractions.size() == 0) begin
      $display("rational_fraction_alu_core_test OK");
    end else begin
      $display("rational_fraction_alu_core_test NOT OK");
    end
    $finish;
  end

  // Timeout guard: even if all 1523 items took the worst case, this would leave a
  // wide margin.
  initial begin
    #1_000_000_000;
    $display("rational_fraction_alu_core_test NOT OK");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/rfa_pkg.sv
hw/rtl/rfa_if.sv
hw/rtl/rfa_serial_div.sv
hw/rtl/rfa_serial_mul.sv
hw/rtl/rational_fraction_alu_core.sv
sim/rational_fraction_alu_core_test.sv
